// File: design/gate_pulse_delay_queue_top_defines.svh
// ---------------------------------------------------------------------------
// gate pulse delay queue assertion macros
// shared assertion forms for the checker of the top level
// ---------------------------------------------------------------------------
`ifndef GATE_PULSE_DELAY_QUEUE_TOP_DEFINES_SVH
`define GATE_PULSE_DELAY_QUEUE_TOP_DEFINES_SVH

// property checked while out of reset
`define GPDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define GPDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/gpdq_pkg.sv
// ---------------------------------------------------------------------------
// gate pulse delay queue package
// shared types and constants of the front end, back end and top level
// ---------------------------------------------------------------------------
package gpdq_pkg;

   localparam int DELAY_BITS = 16;

   // edge seen on the sampled gate for one transaction
   typedef struct packed {
      logic fall;
      logic rise;
   } edge_type;

   localparam int EDGE_BITS = $bits(edge_type);

endpackage

// File: design/gpdq_front.sv
// ---------------------------------------------------------------------------
// gate pulse delay queue front end
// keeps the tick count and the last gate level, classifies each transaction
// into a gate edge and computes its candidate start time
// ---------------------------------------------------------------------------
module gpdq_front #(
   parameter int TIME_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_gate_level,
   input  logic [gpdq_pkg::DELAY_BITS-1:0]   req_delay_count,
   input  logic                              queue_full,
   output logic                              push_valid,
   output gpdq_pkg::edge_type                push_edge,
   output logic [TIME_BITS-1:0]              push_tick,
   output logic [TIME_BITS-1:0]              push_start,
   output logic [TIME_BITS-1:0]              push_delay
);

   logic [TIME_BITS-1:0] tick_ff;
   logic [TIME_BITS-1:0] tick_in;
   logic                 prev_gate_ff;
   logic                 prev_gate_in;

   always_comb begin
      req_stall      = queue_full;
      push_valid     = req_valid & ~queue_full;
      push_edge.fall = prev_gate_ff & ~req_gate_level;
      push_edge.rise = ~prev_gate_ff & req_gate_level;
      push_delay     = TIME_BITS'(req_delay_count);
      push_tick      = tick_ff;
      push_start     = tick_ff + push_delay;
      tick_in        = tick_ff;
      prev_gate_in   = prev_gate_ff;
      if (push_valid) begin
         tick_in      = tick_ff + 1'b1;
         prev_gate_in = req_gate_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         prev_gate_ff <= 1'b1;
      end else begin
         tick_ff      <= tick_in;
         prev_gate_ff <= prev_gate_in;
      end
   end

endmodule

// File: design/gpdq_fifo.sv
// ---------------------------------------------------------------------------
// gate pulse delay queue command fifo
// two-entry register queue between the front end and the back end
// ---------------------------------------------------------------------------
module gpdq_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);

   localparam int ENTRIES = 2;

   logic [WIDTH-1:0] mem_ff [ENTRIES];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      full      = (count_ff == 2'(ENTRIES));
      pop_valid = (count_ff != 2'd0);
      pop_data  = mem_ff[rd_ptr_ff];
      do_push   = push_valid & ~full;
      do_pop    = pop_valid & pop_ready;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/gpdq_back.sv
// ---------------------------------------------------------------------------
// gate pulse delay queue back end
// owns the pulse slots, schedules edges into the write slot, drives the
// output level from the read slot and registers the response
// ---------------------------------------------------------------------------
module gpdq_back #(
   parameter int QUEUE_DEPTH = 4,
   parameter int TIME_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  gpdq_pkg::edge_type   cmd_edge,
   input  logic [TIME_BITS-1:0] cmd_tick,
   input  logic [TIME_BITS-1:0] cmd_start,
   input  logic [TIME_BITS-1:0] cmd_delay,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_pulse_level,
   output logic                 rsp_edge_dropped
);

   localparam int           PW          = $clog2(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_SLOT  = PW'(QUEUE_DEPTH - 1);
   localparam logic [2:0]   FLAG_NONE   = 3'b000;
   localparam logic [2:0]   FLAG_ACTIVE = 3'b001;
   localparam logic [2:0]   FLAG_LEAD   = 3'b010;
   localparam logic [2:0]   FLAG_TRAIL  = 3'b100;

   logic [TIME_BITS-1:0] start_ff [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] stop_ff  [QUEUE_DEPTH];
   logic [2:0]           flags_ff [QUEUE_DEPTH];
   logic [2:0]           flags_in [QUEUE_DEPTH];
   logic [PW-1:0]        wr_slot_ff;
   logic [PW-1:0]        wr_slot_in;
   logic [PW-1:0]        rd_slot_ff;
   logic [PW-1:0]        rd_slot_in;
   logic                 awaiting_ff;
   logic                 awaiting_in;
   logic [TIME_BITS-1:0] lead_delay_ff;
   logic [TIME_BITS-1:0] lead_delay_in;
   logic                 level_ff;
   logic                 level_in;
   logic                 rsp_valid_ff;
   logic                 rsp_level_ff;
   logic                 rsp_dropped_ff;
   logic                 out_free;
   logic                 lead_take;
   logic                 trail_take;
   logic                 dropped;
   logic                 same_slot;
   logic [TIME_BITS-1:0] stop_new;
   logic [TIME_BITS-1:0] start_rd;
   logic [TIME_BITS-1:0] stop_rd;
   logic [2:0]           flags_rd;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] slot);
      next_slot = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   always_comb begin
      out_free      = ~rsp_valid_ff | ~rsp_stall;
      cmd_pop       = cmd_valid & out_free;
      flags_in      = flags_ff;
      wr_slot_in    = wr_slot_ff;
      rd_slot_in    = rd_slot_ff;
      awaiting_in   = awaiting_ff;
      lead_delay_in = lead_delay_ff;
      level_in      = level_ff;
      lead_take     = 1'b0;
      trail_take    = 1'b0;
      dropped       = 1'b0;
      stop_new      = cmd_tick + lead_delay_ff;

      // edge handling on the write slot
      if (cmd_edge.fall && !awaiting_ff) begin
         if (flags_ff[wr_slot_ff] == FLAG_NONE) begin
            lead_take = 1'b1;
         end else begin
            dropped = 1'b1;
         end
      end else if (cmd_edge.rise && awaiting_ff) begin
         trail_take = 1'b1;
      end
      if (lead_take) begin
         flags_in[wr_slot_ff] = FLAG_LEAD | FLAG_ACTIVE;
         awaiting_in          = 1'b1;
         lead_delay_in        = cmd_delay;
      end
      if (trail_take) begin
         flags_in[wr_slot_ff] = flags_ff[wr_slot_ff] | FLAG_TRAIL;
         wr_slot_in           = next_slot(wr_slot_ff);
         awaiting_in          = 1'b0;
      end

      // output compare on the read slot, with bypass of this transaction's write
      same_slot = (rd_slot_ff == wr_slot_ff);
      start_rd  = (lead_take && same_slot) ? cmd_start : start_ff[rd_slot_ff];
      stop_rd   = (trail_take && same_slot) ? stop_new : stop_ff[rd_slot_ff];
      flags_rd  = flags_in[rd_slot_ff];
      if (((flags_rd & FLAG_LEAD) != FLAG_NONE) && (cmd_tick == start_rd)) begin
         level_in             = 1'b1;
         flags_in[rd_slot_ff] = flags_rd & ~FLAG_LEAD;
      end
      if (((flags_rd & FLAG_TRAIL) != FLAG_NONE) && (cmd_tick == stop_rd)) begin
         level_in             = 1'b0;
         flags_in[rd_slot_ff] = FLAG_NONE;
         rd_slot_in           = next_slot(rd_slot_ff);
      end

      rsp_valid        = rsp_valid_ff;
      rsp_pulse_level  = rsp_level_ff;
      rsp_edge_dropped = rsp_dropped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            flags_ff[i] <= FLAG_NONE;
         end
         wr_slot_ff   <= '0;
         rd_slot_ff   <= '0;
         awaiting_ff  <= 1'b0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_pop) begin
            flags_ff    <= flags_in;
            wr_slot_ff  <= wr_slot_in;
            rd_slot_ff  <= rd_slot_in;
            awaiting_ff <= awaiting_in;
            level_ff    <= level_in;
         end
         if (out_free) begin
            rsp_valid_ff <= cmd_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         lead_delay_ff  <= lead_delay_in;
         rsp_level_ff   <= level_in;
         rsp_dropped_ff <= dropped;
         if (lead_take) begin
            start_ff[wr_slot_ff] <= cmd_start;
         end
         if (trail_take) begin
            stop_ff[wr_slot_ff] <= stop_new;
         end
      end
   end

endmodule

// File: design/gate_pulse_delay_queue_top.sv
// ---------------------------------------------------------------------------
// gate pulse delay queue top level
// delays active-low gate pulses through a small slot queue and replays them
// on the output, one transaction per timer tick
//
//   channel   direction   handshake          payload
//   req       in          req_valid/stall    gate_level, delay_count
//   rsp       out         rsp_valid/stall    pulse_level, edge_dropped
//
// one transaction per cycle sustained while responses are not stalled; a request
// passes through the two-entry command fifo and then the response register, each
// adding one register stage; no clearing pass, ready the cycle after reset
// reset is synchronous and active high
// a response stall backs up into the fifo and then stalls requests
// ---------------------------------------------------------------------------
module gate_pulse_delay_queue_top #(
   parameter int QUEUE_DEPTH = 4,
   parameter int TIME_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_gate_level,
   input  logic [gpdq_pkg::DELAY_BITS-1:0] req_delay_count,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_pulse_level,
   output logic                            rsp_edge_dropped
);

   localparam int CMD_BITS = gpdq_pkg::EDGE_BITS + 3 * TIME_BITS;

   logic                 queue_full;
   logic                 push_valid;
   gpdq_pkg::edge_type   push_edge;
   logic [TIME_BITS-1:0] push_tick;
   logic [TIME_BITS-1:0] push_start;
   logic [TIME_BITS-1:0] push_delay;
   logic [CMD_BITS-1:0]  push_data;
   logic                 cmd_valid;
   logic [CMD_BITS-1:0]  cmd_data;
   logic                 cmd_pop;
   gpdq_pkg::edge_type   cmd_edge;
   logic [TIME_BITS-1:0] cmd_tick;
   logic [TIME_BITS-1:0] cmd_start;
   logic [TIME_BITS-1:0] cmd_delay;

   assign push_data = {push_edge, push_tick, push_start, push_delay};
   assign {cmd_edge, cmd_tick, cmd_start, cmd_delay} = cmd_data;

   gpdq_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_gate_level  (req_gate_level),
      .req_delay_count (req_delay_count),
      .queue_full      (queue_full),
      .push_valid      (push_valid),
      .push_edge       (push_edge),
      .push_tick       (push_tick),
      .push_start      (push_start),
      .push_delay      (push_delay)
   );

   gpdq_fifo #(
      .WIDTH (CMD_BITS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (cmd_valid),
      .pop_data   (cmd_data),
      .pop_ready  (cmd_pop)
   );

   gpdq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_edge         (cmd_edge),
      .cmd_tick         (cmd_tick),
      .cmd_start        (cmd_start),
      .cmd_delay        (cmd_delay),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pulse_level  (rsp_pulse_level),
      .rsp_edge_dropped (rsp_edge_dropped)
   );

endmodule

// File: design/gpdq_checker.sv
// ---------------------------------------------------------------------------
// gate pulse delay queue checker
// port-level checks on transaction counts, reset and response hold
// ---------------------------------------------------------------------------
`include "gate_pulse_delay_queue_top_defines.svh"

module gpdq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_pulse_level,
   input logic rsp_edge_dropped
);

   logic       req_take;
   logic       rsp_take;
   logic       rsp_held;
   logic [1:0] rsp_data;
   logic [2:0] pending_ff;
   logic [2:0] pending_in;

   always_comb begin
      req_take   = req_valid & ~req_stall;
      rsp_take   = rsp_valid & ~rsp_stall;
      rsp_held   = rsp_valid & rsp_stall;
      rsp_data   = {rsp_pulse_level, rsp_edge_dropped};
      pending_in = pending_ff + 3'(req_take) - 3'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `GPDQ_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp valid after reset")

   `GPDQ_ASSERT(a_rsp_owed, clock, reset, rsp_valid |-> pending_ff != 3'd0, "rsp without request")

   `GPDQ_ASSERT(a_pending_bound, clock, reset, pending_ff <= 3'd3, "too many in flight")

   `GPDQ_ASSERT(a_hold, clock, reset, rsp_held |=> rsp_valid && $stable(rsp_data), "rsp changed")

endmodule

bind gate_pulse_delay_queue_top gpdq_checker u_gpdq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pulse_level  (rsp_pulse_level),
   .rsp_edge_dropped (rsp_edge_dropped)
);

// File: tb/tb_gate_pulse_delay_queue_top.sv
// ---------------------------------------------------------------------------
// gate pulse delay queue testbench
// drives gate ticks through the request channel with random gaps and random
// response stalls. a built-in timer and slot queue predicts pulse_level and
// edge_dropped for every tick, and each response is checked in order.
// covers single pulses, zero delay, head slot busy drops and random pulse
// trains
// ---------------------------------------------------------------------------
module tb_gate_pulse_delay_queue_top;

   localparam int QDEPTH         = 4;
   localparam int TBITS          = 16;
   localparam int DBITS          = gpdq_pkg::DELAY_BITS;
   localparam int WATCHDOG_LIMIT = 1000;

   localparam logic [2:0] SLOT_FREE   = 3'b000;
   localparam logic [2:0] SLOT_ACTIVE = 3'b001;
   localparam logic [2:0] SLOT_LEAD   = 3'b010;
   localparam logic [2:0] SLOT_TRAIL  = 3'b100;

   typedef struct packed {
      logic pulse_level;
      logic edge_dropped;
   } pulse_sample_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_gate_level = 1'b1;
   logic [DBITS-1:0] req_delay_count = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_pulse_level;
   logic             rsp_edge_dropped;

   // timer and slot queue state
   logic [TBITS-1:0] timer_now = '0;
   logic             gate_seen = 1'b1;
   logic             capture_open = 1'b0;
   logic [TBITS-1:0] capture_at = '0;
   logic [TBITS-1:0] slot_start_at [QDEPTH];
   logic [TBITS-1:0] slot_stop_at [QDEPTH];
   logic [2:0]       slot_state [QDEPTH] = '{default: SLOT_FREE};
   logic [1:0]       fill_ptr = '0;
   logic [1:0]       play_ptr = '0;
   logic             pulse_now = 1'b0;

   pulse_sample_type expected_samples[$];

   bit quiet = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;
   int items_sent = 0;
   int results_checked = 0;
   int drops_seen = 0;
   int rises_seen = 0;
   int error_count = 0;
   logic last_pulse = 1'b0;

   gate_pulse_delay_queue_top #(
      .QUEUE_DEPTH(QDEPTH),
      .TIME_BITS  (TBITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_gate_level  (req_gate_level),
      .req_delay_count (req_delay_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pulse_level (rsp_pulse_level),
      .rsp_edge_dropped(rsp_edge_dropped)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic pulse_sample_type advance_gate_timer(input logic gate,
                                                           input logic [TBITS-1:0] delay);
      pulse_sample_type sample;
      logic [TBITS-1:0] width;
      sample.edge_dropped = 1'b0;
      if (gate_seen && !gate && !capture_open) begin
         if (slot_state[fill_ptr] == SLOT_FREE) begin
            capture_at = timer_now;
            slot_start_at[fill_ptr] = timer_now + delay;
            slot_state[fill_ptr] = SLOT_LEAD | SLOT_ACTIVE;
            capture_open = 1'b1;
         end else begin
            sample.edge_dropped = 1'b1;
         end
      end else if (!gate_seen && gate && capture_open) begin
         width = timer_now - capture_at;
         slot_stop_at[fill_ptr] = slot_start_at[fill_ptr] + width;
         slot_state[fill_ptr] = slot_state[fill_ptr] | SLOT_TRAIL;
         fill_ptr = fill_ptr + 2'd1;
         capture_open = 1'b0;
      end
      gate_seen = gate;
      // start compare first, then stop compare on the playing slot
      if ((slot_state[play_ptr] & SLOT_LEAD) != SLOT_FREE
          && timer_now == slot_start_at[play_ptr]) begin
         pulse_now = 1'b1;
         slot_state[play_ptr] = slot_state[play_ptr] & ~SLOT_LEAD;
      end
      if ((slot_state[play_ptr] & SLOT_TRAIL) != SLOT_FREE
          && timer_now == slot_stop_at[play_ptr]) begin
         pulse_now = 1'b0;
         slot_state[play_ptr] = SLOT_FREE;
         play_ptr = play_ptr + 2'd1;
      end
      timer_now = timer_now + 1'b1;
      sample.pulse_level = pulse_now;
      return sample;
   endfunction

   function automatic bit queue_drained();
      queue_drained = !capture_open && fill_ptr == play_ptr
                      && slot_state[play_ptr] == SLOT_FREE;
   endfunction

   function automatic logic [DBITS-1:0] draw_delay();
      draw_delay = DBITS'($urandom);
   endfunction

   task automatic drive_tick(input logic gate, input logic [DBITS-1:0] delay);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_gate_level <= gate;
      req_delay_count <= delay;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_samples.push_back(advance_gate_timer(gate, delay));
      items_sent++;
   endtask

   task automatic idle_ticks(input int count);
      repeat (count) drive_tick(1'b1, draw_delay());
   endtask

   task automatic test_single_pulse;
      idle_ticks(2);
      drive_tick(1'b0, 16'd2);
      drive_tick(1'b0, 16'hFFFF);
      drive_tick(1'b0, 16'h0000);
      drive_tick(1'b0, draw_delay());
      drive_tick(1'b1, 16'hFFFF);
      idle_ticks(8);
   endtask

   task automatic test_zero_delay;
      drive_tick(1'b0, 16'd0);
      drive_tick(1'b1, 16'd0);
      idle_ticks(3);
   endtask

   // fill all slots with pending pulses so the next leading edge finds the head busy
   task automatic test_busy_head_drop;
      repeat (QDEPTH) begin
         drive_tick(1'b0, 16'd30);
         drive_tick(1'b1, draw_delay());
      end
      drive_tick(1'b0, 16'd1);
      drive_tick(1'b1, 16'd0);
      idle_ticks(40);
   endtask

   task automatic test_random_traffic;
      int first_item;
      int kind;
      logic [DBITS-1:0] lead_delay;
      first_item = items_sent;
      lead_delay = DBITS'($urandom_range(0, 12));
      while (items_sent - first_item < 480) begin
         if ($urandom_range(0, 9) == 0) quiet = !quiet;
         // new delay only once the slot queue is empty, so pulses replay in order
         if (queue_drained() && $urandom_range(0, 3) == 0) begin
            lead_delay = DBITS'($urandom_range(0, 40));
         end
         kind = $urandom_range(0, 9);
         if (kind < 8) begin
            idle_ticks($urandom_range(0, 4));
            drive_tick(1'b0, lead_delay);
            repeat ($urandom_range(1, 8)) drive_tick(1'b0, draw_delay());
            drive_tick(1'b1, draw_delay());
         end else begin
            repeat ($urandom_range(1, 6))
               drive_tick(1'($urandom_range(0, 1)), lead_delay);
         end
      end
      quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      pulse_sample_type exp_sample;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("tb_gate_pulse_delay_queue_top NOT OK");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %b %b",
                        $time, rsp_pulse_level, rsp_edge_dropped);
               error_count++;
            end else begin
               exp_sample = expected_samples.pop_front();
               if (rsp_pulse_level !== exp_sample.pulse_level) begin
                  $display("%0t: pulse_level expected %b actual %b", $time,
                           exp_sample.pulse_level, rsp_pulse_level);
                  error_count++;
               end
               if (rsp_edge_dropped !== exp_sample.edge_dropped) begin
                  $display("%0t: edge_dropped expected %b actual %b", $time,
                           exp_sample.edge_dropped, rsp_edge_dropped);
                  error_count++;
               end
            end
            results_checked++;
            if (rsp_edge_dropped === 1'b1) drops_seen++;
            if (rsp_pulse_level === 1'b1 && !last_pulse) rises_seen++;
            last_pulse = (rsp_pulse_level === 1'b1);
            stall_left = quiet ? 0 : $urandom_range(0, 6);
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_single_pulse();
      test_zero_delay();
      test_busy_head_drop();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("run covered %0d ticks sent and %0d responses checked", items_sent,
               results_checked);
      $display("output pulses seen %0d, dropped leading edges seen %0d", rises_seen,
               drops_seen);
      if (error_count == 0) begin
         $display("tb_gate_pulse_delay_queue_top OK");
      end else begin
         $display("tb_gate_pulse_delay_queue_top NOT OK");
      end
      $finish;
   end

endmodule
